// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/t2g_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package t2g_pkg;

    // Table size and coordinate widths.
    localparam int MAX_EXONS  = 32;
    localparam int COORD_BITS = 32;
    localparam int WORD_W     = 32;
    localparam int LEN_W      = 16;
    localparam int IDX_W      = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
    localparam int CNT_W      = $clog2(MAX_EXONS + 1);
    // Gap between neighboring exons, signed, one bit of headroom.
    localparam int GAP_W      = COORD_BITS + 2;
    // Running coordinate width: sums of up to MAX_EXONS signed gaps.
    localparam int XW         = COORD_BITS + CNT_W + 4;

    // Command queue between the front and the back end.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        OP_MATCH = 2'd0,
        OP_SKIP  = 2'd1,
        OP_NONE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_EXON  = 2'd1,
        ST_PAST_END = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOC,
        BK_CHK,
        BK_EMIT,
        BK_ERR
    } bk_state_t;

    // One classified word as it sits in the queue.
    typedef struct packed {
        kind_t                  kind;
        logic                   first_exon;
        logic [COORD_BITS-1:0]  ex_begin;
        logic [COORD_BITS-1:0]  ex_finish;
        logic                   minus;
        logic [WORD_W-1:0]      read_offset;
        logic [LEN_W-1:0]       read_bases;
    } cmd_t;

    // One exon table entry; gap is begin minus the previous finish minus one.
    typedef struct packed {
        logic [COORD_BITS-1:0]  ex_begin;
        logic [COORD_BITS-1:0]  ex_finish;
        logic [GAP_W-1:0]       gap;
    } exon_t;

    // One result word.
    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  genome_start;
        op_t                op;
        logic [WORD_W-1:0]  op_len;
        logic               minus;
        status_t            status;
        logic               last;
    } res_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== design/transcript_to_genome_cigar.sv =====
// A two-word queue takes new words while a query runs, until it is full.
// A query walks the table up to three times through one read port (locate, check,
// emit); the back end pops no new word from the queue until the query is done.
// Results leave one per cycle at most, each registered after it is formed; the receiver
// cannot stall, so each result word is shown for exactly one cycle under strobe.
// rst_n low clears the queue, the exon count and the transcript length at once.
`timescale 1ns / 1ps
`default_nettype none

module transcript_to_genome_cigar (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic                        first_exon,
    input  logic [t2g_pkg::WORD_W-1:0]  exon_begin,
    input  logic [t2g_pkg::WORD_W-1:0]  exon_finish,
    input  logic                        trans_minus,
    input  logic                        read_flip,
    input  logic [t2g_pkg::WORD_W-1:0]  read_offset,
    input  logic [t2g_pkg::LEN_W-1:0]   read_bases,
    output logic                        strobe,
    output logic [t2g_pkg::WORD_W-1:0]  genome_start,
    output logic [1:0]                  op,
    output logic [t2g_pkg::WORD_W-1:0]  op_len,
    output logic                        minus_out,
    output logic [1:0]                  status,
    output logic                        last
);
    import t2g_pkg::*;

    q_stat_t q_stat;
    cmd_t    cmd_in;
    cmd_t    cmd_head;
    logic    push;
    logic    pop;
    res_t    res;

    // Front: accept and classify words.
    t2g_front u_front (
        .start       (start),
        .kind        (kind),
        .first_exon  (first_exon),
        .exon_begin  (exon_begin),
        .exon_finish (exon_finish),
        .trans_minus (trans_minus),
        .read_flip   (read_flip),
        .read_offset (read_offset),
        .read_bases  (read_bases),
        .q_stat      (q_stat),
        .busy        (busy),
        .push        (push),
        .cmd         (cmd_in)
    );

    // Short queue between the two sides.
    t2g_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .pop   (pop),
        .dout  (cmd_head),
        .stat  (q_stat)
    );

    // Back: table updates and query walks.
    t2g_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_stat.empty),
        .q_head  (cmd_head),
        .q_pop   (pop),
        .res     (res)
    );

    assign strobe       = res.valid;
    assign genome_start = res.genome_start;
    assign op           = res.op;
    assign op_len       = res.op_len;
    assign minus_out    = res.minus;
    assign status       = res.status;
    assign last         = res.last;

endmodule

`default_nettype wire

// ===== design/t2g_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module t2g_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/t2g_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module t2g_front (
    input  logic                          start,
    input  logic                          kind,
    input  logic                          first_exon,
    input  logic [t2g_pkg::WORD_W-1:0]    exon_begin,
    input  logic [t2g_pkg::WORD_W-1:0]    exon_finish,
    input  logic                          trans_minus,
    input  logic                          read_flip,
    input  logic [t2g_pkg::WORD_W-1:0]    read_offset,
    input  logic [t2g_pkg::LEN_W-1:0]     read_bases,
    input  t2g_pkg::q_stat_t              q_stat,
    output logic                          busy,
    output logic                          push,
    output t2g_pkg::cmd_t                 cmd
);
    import t2g_pkg::*;

    logic is_query;

    // A word is taken whenever the queue has room.
    assign busy     = q_stat.full;
    assign push     = start && !q_stat.full;
    assign is_query = (kind == KIND_QUERY);

    // Classify the word and keep only the fields that its kind uses.
    always_comb
    begin
        cmd             = '0;
        cmd.kind        = is_query ? KIND_QUERY : KIND_LOAD;
        if (is_query)
        begin
            cmd.minus       = trans_minus ^ read_flip;
            cmd.read_offset = read_offset;
            cmd.read_bases  = read_bases;
        end
        else
        begin
            cmd.first_exon  = first_exon;
            cmd.ex_begin    = exon_begin;
            cmd.ex_finish   = exon_finish;
        end
    end

endmodule

`default_nettype wire

// ===== design/t2g_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module t2g_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  t2g_pkg::cmd_t     din,
    input  logic              pop,
    output t2g_pkg::cmd_t     dout,
    output t2g_pkg::q_stat_t  stat
);
    import t2g_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

    // Full is the upper bit of the status, empty the lower.
    assign dout = mem_reg[rptr_reg];
    assign stat = {(cnt_reg == QCNT_W'(QDEPTH)), (cnt_reg == '0)};

endmodule

`default_nettype wire

// ===== design/t2g_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module t2g_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  t2g_pkg::cmd_t  q_head,
    output logic           q_pop,
    output t2g_pkg::res_t  res
);
    import t2g_pkg::*;

    bk_state_t             state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [WORD_W-1:0]     tlen_reg, tlen_next;
    logic [COORD_BITS-1:0] lfin_reg, lfin_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      sidx_reg, sidx_next;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  rem_reg, rem_next;
    logic signed [XW-1:0]  t_reg, t_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  minus_reg, minus_next;
    logic                  skip_done_reg, skip_done_next;
    status_t               err_reg, err_next;
    res_t                  res_reg, res_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [$bits(exon_t)-1:0] ram_rdata;

    exon_t                 ent;
    exon_t                 wr_ent;
    logic signed [XW-1:0]  b_x, f_x, gap_x, x_cur, pos, m_len, rem_sub;
    logic signed [XW-1:0]  len_x, lenr_x, off_x, tl_x, t_calc;
    logic                  hit, fits, m_pos, last_ent, at_start;
    logic [CNT_W-1:0]      cnt_eff;
    logic [WORD_W-1:0]     tl_eff;
    logic [GAP_W-1:0]      new_gap;

    // Exon table; the read address follows the next index so the data
    // for the current index is always on the read port.
    t2g_ram #(
        .WIDTH ($bits(exon_t)),
        .DEPTH (MAX_EXONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Current entry widened to the running coordinate width.
    assign ent   = exon_t'(ram_rdata);
    assign b_x   = $signed({{(XW - COORD_BITS){1'b0}}, ent.ex_begin});
    assign f_x   = $signed({{(XW - COORD_BITS){1'b0}}, ent.ex_finish});
    assign gap_x = $signed({{(XW - GAP_W){ent.gap[GAP_W-1]}}, ent.gap});

    // Locate step: shifted offset against the current exon.
    assign x_cur = (idx_reg == '0) ? (t_reg + b_x) : (x_reg + gap_x);
    assign hit   = (x_cur >= b_x) && (x_cur <= f_x);

    // Walk step: the read fits when what remains is no longer than the
    // rest of this exon.
    assign at_start = (idx_reg == sidx_reg);
    assign pos      = at_start ? x_reg : b_x;
    assign m_len    = f_x - pos + $signed(XW'(1));
    assign fits     = (rem_reg <= m_len);
    assign m_pos    = (m_len > 0);
    assign rem_sub  = rem_reg - m_len;
    assign last_ent = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    // Query setup: mirror the offset on the minus strand.
    assign len_x  = $signed({{(XW - LEN_W){1'b0}}, q_head.read_bases});
    assign lenr_x = $signed({{(XW - LEN_W){1'b0}}, len_reg});
    assign off_x  = $signed({{(XW - WORD_W){1'b0}}, q_head.read_offset});
    assign tl_x   = $signed({{(XW - WORD_W){1'b0}}, tlen_reg});
    assign t_calc = q_head.minus ? (tl_x - (off_x + len_x)) : off_x;

    // Load setup: a first exon restarts the table.
    assign cnt_eff = q_head.first_exon ? '0 : cnt_reg;
    assign tl_eff  = q_head.first_exon ? '0 : tlen_reg;
    assign new_gap = (cnt_eff == '0) ? '0
                   : ({2'b00, q_head.ex_begin} - {2'b00, lfin_reg} - GAP_W'(1));
    assign wr_ent  = '{ex_begin: q_head.ex_begin, ex_finish: q_head.ex_finish, gap: new_gap};
    assign ram_waddr = cnt_eff[IDX_W-1:0];

    // Next state and result word.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tlen_next      = tlen_reg;
        lfin_next      = lfin_reg;
        idx_next       = idx_reg;
        sidx_next      = sidx_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        t_next         = t_reg;
        len_next       = len_reg;
        minus_next     = minus_reg;
        skip_done_next = skip_done_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        res_next.valid = 1'b0;
        ram_we         = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == KIND_LOAD)
                    begin
                        // Append the exon unless the table is full.
                        if (cnt_eff < CNT_W'(MAX_EXONS))
                        begin
                            ram_we    = 1'b1;
                            cnt_next  = cnt_eff + CNT_W'(1);
                            tlen_next = tl_eff + q_head.ex_finish - q_head.ex_begin
                                      + WORD_W'(1);
                            lfin_next = q_head.ex_finish;
                        end
                    end
                    else
                    begin
                        minus_next = q_head.minus;
                        len_next   = q_head.read_bases;
                        t_next     = t_calc;
                        idx_next   = '0;
                        if (cnt_reg == '0)
                        begin
                            x_next     = '0;
                            err_next   = ST_NO_EXON;
                            state_next = BK_ERR;
                        end
                        else
                        begin
                            state_next = BK_LOC;
                        end
                    end
                end
            end

            BK_LOC:
            begin
                // Find the exon that holds the read start.
                if (hit)
                begin
                    x_next     = x_cur;
                    sidx_next  = idx_reg;
                    rem_next   = lenr_x;
                    state_next = BK_CHK;
                end
                else if (last_ent)
                begin
                    x_next     = '0;
                    err_next   = ST_NO_EXON;
                    state_next = BK_ERR;
                end
                else
                begin
                    x_next   = x_cur;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            BK_CHK:
            begin
                // Dry walk: does the read end inside the table?
                if (fits)
                begin
                    idx_next       = sidx_reg;
                    rem_next       = lenr_x;
                    skip_done_next = 1'b0;
                    state_next     = BK_EMIT;
                end
                else if (last_ent)
                begin
                    err_next   = ST_PAST_END;
                    state_next = BK_ERR;
                end
                else
                begin
                    rem_next = rem_sub;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            BK_EMIT:
            begin
                res_next.genome_start = x_reg[WORD_W-1:0];
                res_next.minus        = minus_reg;
                res_next.status       = ST_OK;
                res_next.last         = 1'b0;
                if (!at_start && !skip_done_reg)
                begin
                    // Intron skip in front of every exon after the one where the read starts.
                    res_next.valid  = 1'b1;
                    res_next.op     = OP_SKIP;
                    res_next.op_len = gap_x[WORD_W-1:0];
                    skip_done_next  = 1'b1;
                end
                else if (fits)
                begin
                    res_next.valid  = 1'b1;
                    res_next.op     = OP_MATCH;
                    res_next.op_len = rem_reg[WORD_W-1:0];
                    res_next.last   = 1'b1;
                    state_next      = BK_IDLE;
                end
                else
                begin
                    res_next.valid  = m_pos;
                    res_next.op     = OP_MATCH;
                    res_next.op_len = m_len[WORD_W-1:0];
                    rem_next        = rem_sub;
                    idx_next        = idx_reg + IDX_W'(1);
                    skip_done_next  = 1'b0;
                end
            end

            BK_ERR:
            begin
                res_next.valid        = 1'b1;
                res_next.genome_start = x_reg[WORD_W-1:0];
                res_next.op           = OP_NONE;
                res_next.op_len       = '0;
                res_next.minus        = minus_reg;
                res_next.status       = err_reg;
                res_next.last         = 1'b1;
                state_next            = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            tlen_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tlen_reg  <= tlen_next;
            res_reg   <= res_next;
        end
    end

    // Working registers of the walk.
    always_ff @(posedge clk)
    begin
        lfin_reg      <= lfin_next;
        idx_reg       <= idx_next;
        sidx_reg      <= sidx_next;
        x_reg         <= x_next;
        rem_reg       <= rem_next;
        t_reg         <= t_next;
        len_reg       <= len_next;
        minus_reg     <= minus_next;
        skip_done_reg <= skip_done_next;
        err_reg       <= err_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/t2g_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module t2g_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        strobe,
    input logic [t2g_pkg::WORD_W-1:0]  genome_start,
    input logic [1:0]                  op,
    input logic [t2g_pkg::WORD_W-1:0]  op_len,
    input logic [1:0]                  status,
    input logic                        last
);
    import t2g_pkg::*;

    // An error is reported as one final word with no operation.
    `ASSERT_SAME(a_err_single, strobe && status != ST_OK, op == OP_NONE && last && op_len == '0, "error word is not a single empty final word")

    // A start outside every exon has no genomic start.
    `ASSERT_SAME(a_miss_zero, strobe && status == ST_NO_EXON, genome_start == '0, "start miss with nonzero genome start")

    // Only the final word of a query may carry no operation or an error.
    `ASSERT_SAME(a_mid_ok, strobe && !last, status == ST_OK && op != OP_NONE, "word before the last is not a plain operation")

    // A partial match is always followed at once by an intron skip.
    `ASSERT_NEXT(a_match_skip, strobe && op == OP_MATCH && !last, strobe && op == OP_SKIP, "partial match not followed by a skip")

endmodule

bind transcript_to_genome_cigar t2g_checker u_t2g_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .strobe       (strobe),
    .genome_start (genome_start),
    .op           (op),
    .op_len       (op_len),
    .status       (status),
    .last         (last)
);

`default_nettype wire

// ===== dv/transcript_to_genome_cigar_tb.sv =====
`timescale 1ns / 1ps

module transcript_to_genome_cigar_tb;
    import t2g_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * MAX_EXONS + 16;
    localparam int EXP_DEPTH    = 1024;

    // One predicted result word.
    typedef struct {
        logic [WORD_W-1:0] genome_start;
        op_t               op;
        logic [WORD_W-1:0] op_len;
        logic              minus;
        status_t           status;
        logic              last;
    } cigar_word_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                kind        = 1'b0;
    logic                first_exon  = 1'b0;
    logic [WORD_W-1:0]   exon_begin  = '0;
    logic [WORD_W-1:0]   exon_finish = '0;
    logic                trans_minus = 1'b0;
    logic                read_flip   = 1'b0;
    logic [WORD_W-1:0]   read_offset = '0;
    logic [LEN_W-1:0]    read_bases  = '0;
    logic                busy;
    logic                strobe;
    logic [WORD_W-1:0]   genome_start;
    logic [1:0]          op;
    logic [WORD_W-1:0]   op_len;
    logic                minus_out;
    logic [1:0]          status;
    logic                last;

    // Shadow copy of the exon table and its running length.
    logic [WORD_W-1:0]   exon_start_tab [0:MAX_EXONS-1];
    logic [WORD_W-1:0]   exon_end_tab   [0:MAX_EXONS-1];
    int                  exon_total = 0;
    logic [WORD_W-1:0]   tx_length  = '0;

    // Predicted words in a ring, oldest at exp_head.
    cigar_word_t         expected_ops [EXP_DEPTH];
    int                  exp_head    = 0;
    int                  exp_tail    = 0;
    int                  fail_count  = 0;
    int                  items_sent  = 0;
    int                  idle_pct    = 0;
    int unsigned         cycle_count = 0;

    transcript_to_genome_cigar i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .first_exon   (first_exon),
        .exon_begin   (exon_begin),
        .exon_finish  (exon_finish),
        .trans_minus  (trans_minus),
        .read_flip    (read_flip),
        .read_offset  (read_offset),
        .read_bases   (read_bases),
        .strobe       (strobe),
        .genome_start (genome_start),
        .op           (op),
        .op_len       (op_len),
        .minus_out    (minus_out),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off as a failure once the cycle counter reaches its limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("transcript_to_genome_cigar regression: fail");
            $finish;
        end
    end

    // Appends one exon to the shadow table; a full table drops the exon.
    function automatic void append_exon(input logic clear, input logic [WORD_W-1:0] b,
                                        input logic [WORD_W-1:0] f);
        if (clear)
        begin
            exon_total = 0;
            tx_length  = '0;
        end
        if (exon_total < MAX_EXONS)
        begin
            exon_start_tab[exon_total] = b;
            exon_end_tab[exon_total]   = f;
            tx_length  = tx_length + f - b + 1;
            exon_total = exon_total + 1;
        end
    endfunction

    function automatic void push_word(input logic [WORD_W-1:0] gs, input op_t o,
                                      input logic [WORD_W-1:0] len, input logic m,
                                      input status_t st, input logic fin);
        cigar_word_t w;
        w.genome_start = gs;
        w.op           = o;
        w.op_len       = len;
        w.minus        = m;
        w.status       = st;
        w.last         = fin;
        expected_ops[exp_tail % EXP_DEPTH] = w;
        exp_tail = exp_tail + 1;
    endfunction

    // Projects one read onto the genome and queues the words it produces.
    function automatic void project_read(input logic m, input logic [WORD_W-1:0] offset,
                                         input logic [LEN_W-1:0] len);
        longint t, base, gap_sum, shift, b, f, g, pos, rem, run, miss, nb;
        int     idx;
        int     n_runs;
        bit     found, past_end, done;
        op_t    run_op [2*MAX_EXONS];
        longint run_len [2*MAX_EXONS];
        t = {32'd0, offset};
        if (m)
            t = longint'({32'd0, tx_length}) - (t + longint'({48'd0, len}));
        found  = 1'b0;
        idx    = 0;
        g      = 0;
        n_runs = 0;
        // Find the exon whose transcript span holds the start.
        if (exon_total > 0)
        begin
            base    = {32'd0, exon_start_tab[0]};
            gap_sum = 0;
            for (int i = 0; i < exon_total && !found; i++)
            begin
                shift = base + gap_sum;
                b     = {32'd0, exon_start_tab[i]};
                f     = {32'd0, exon_end_tab[i]};
                if (t >= b - shift && t <= f - shift)
                begin
                    g     = t + shift;
                    idx   = i;
                    found = 1'b1;
                end
                else if (i + 1 < exon_total)
                begin
                    nb      = {32'd0, exon_start_tab[i + 1]};
                    gap_sum = gap_sum + nb - f - 1;
                end
            end
        end
        if (!found)
        begin
            push_word('0, OP_NONE, '0, m, ST_NO_EXON, 1'b1);
            return;
        end
        // Walk forward from that exon, splitting the read into match and skip runs.
        pos      = g;
        rem      = {48'd0, len};
        past_end = 1'b0;
        done     = 1'b0;
        for (int i = idx; i < exon_total && !done; i++)
        begin
            b = {32'd0, exon_start_tab[i]};
            f = {32'd0, exon_end_tab[i]};
            if (pos >= b && pos + rem - 1 <= f)
            begin
                run_op[n_runs]  = OP_MATCH;
                run_len[n_runs] = rem;
                n_runs          = n_runs + 1;
                done            = 1'b1;
            end
            else if (pos >= b)
            begin
                run = f - pos + 1;
                if (run > 0)
                begin
                    run_op[n_runs]  = OP_MATCH;
                    run_len[n_runs] = run;
                    n_runs          = n_runs + 1;
                end
                if (i + 1 >= exon_total)
                begin
                    past_end = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    nb              = {32'd0, exon_start_tab[i + 1]};
                    miss            = nb - f - 1;
                    run_op[n_runs]  = OP_SKIP;
                    run_len[n_runs] = miss;
                    n_runs          = n_runs + 1;
                    pos = pos + run + miss;
                    rem = rem - run;
                end
            end
        end
        if (past_end)
            push_word(g[31:0], OP_NONE, '0, m, ST_PAST_END, 1'b1);
        else if (n_runs == 0)
            push_word(g[31:0], OP_NONE, '0, m, ST_OK, 1'b1);
        else
            for (int k = 0; k < n_runs; k++)
                push_word(g[31:0], run_op[k], run_len[k][31:0], m, ST_OK,
                          k == n_runs - 1);
    endfunction

    // Drives one word, waits for it to be taken and then idles at random.
    task automatic send_word(input kind_t k, input logic fe, input logic [WORD_W-1:0] eb,
                             input logic [WORD_W-1:0] ef, input logic tm, input logic rf,
                             input logic [WORD_W-1:0] off, input logic [LEN_W-1:0] len);
        start       <= 1'b1;
        kind        <= k;
        first_exon  <= fe;
        exon_begin  <= eb;
        exon_finish <= ef;
        trans_minus <= tm;
        read_flip   <= rf;
        read_offset <= off;
        read_bases  <= len;
        do
            @(posedge clk);
        while (busy);
        items_sent = items_sent + 1;
        if (k == KIND_LOAD)
            append_exon(fe, eb, ef);
        else
            project_read(tm ^ rf, off, len);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Query fields carry noise on a load word.
    task automatic load_exon(input logic fe, input logic [WORD_W-1:0] b,
                             input logic [WORD_W-1:0] f);
        send_word(KIND_LOAD, fe, b, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom, LEN_W'($urandom_range(0, 65535)));
    endtask

    // Load fields carry noise on a query word.
    task automatic query_read(input logic tm, input logic rf, input logic [WORD_W-1:0] off,
                              input logic [LEN_W-1:0] len);
        send_word(KIND_QUERY, 1'($urandom_range(0, 1)), $urandom, $urandom, tm, rf, off, len);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    // Every strobed word is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        cigar_word_t want;
        if (rst_n && strobe)
        begin
            if (exp_head == exp_tail)
            begin
                $error("result word with no prediction pending");
                fail_count = fail_count + 1;
            end
            else
            begin
                want     = expected_ops[exp_head % EXP_DEPTH];
                exp_head = exp_head + 1;
                check_field("genome_start", want.genome_start, genome_start);
                check_field("op", WORD_W'(want.op), WORD_W'(op));
                check_field("op_len", want.op_len, op_len);
                check_field("minus_out", WORD_W'(want.minus), WORD_W'(minus_out));
                check_field("status", WORD_W'(want.status), WORD_W'(status));
                check_field("last", WORD_W'(want.last), WORD_W'(last));
            end
        end
    end

    // A query before any exon has been loaded finds no exon.
    task automatic test_empty_table();
        query_read(1'b0, 1'b0, 32'd0, 16'd1);
    endtask

    // Plus strand over three ordered exons of 10, 5 and 20 bases.
    task automatic test_plus_strand();
        load_exon(1'b1, 32'd100, 32'd109);
        load_exon(1'b0, 32'd200, 32'd204);
        load_exon(1'b0, 32'd300, 32'd319);
        query_read(1'b0, 1'b0, 32'd0, 16'd10);
        query_read(1'b0, 1'b0, 32'd8, 16'd10);
        query_read(1'b0, 1'b0, 32'd0, 16'd35);
        query_read(1'b0, 1'b0, 32'd30, 16'd6);
        query_read(1'b0, 1'b0, 32'd35, 16'd1);
        query_read(1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        query_read(1'b0, 1'b0, 32'd0, 16'd0);
    endtask

    // Strand mirroring, both flip combinations and a mirror below zero.
    task automatic test_minus_strand();
        query_read(1'b1, 1'b0, 32'd0, 16'd5);
        query_read(1'b0, 1'b1, 32'd10, 16'd4);
        query_read(1'b1, 1'b1, 32'd3, 16'd3);
        query_read(1'b1, 1'b0, 32'd30, 16'd10);
    endtask

    // Overlapping and out-of-order exons give negative skips.
    task automatic test_unordered_exons();
        load_exon(1'b1, 32'd500, 32'd520);
        load_exon(1'b0, 32'd510, 32'd530);
        query_read(1'b0, 1'b0, 32'd15, 16'd20);
        load_exon(1'b1, 32'd500, 32'd509);
        load_exon(1'b0, 32'd400, 32'd409);
        load_exon(1'b0, 32'd600, 32'd605);
        query_read(1'b0, 1'b0, 32'd0, 16'd20);
    endtask

    // One exon over the whole coordinate space; its length wraps to zero.
    task automatic test_coord_extremes();
        load_exon(1'b1, 32'd0, 32'hFFFF_FFFF);
        query_read(1'b0, 1'b0, 32'hFFFF_FFF0, 16'd16);
        query_read(1'b1, 1'b0, 32'd0, 16'd1);
    endtask

    // Loads one random transcript and sends a few reads against it.
    task automatic rand_transcript();
        int                n_exons, n_reads, pick, span, len_max;
        logic [WORD_W-1:0] cur, b, f, off;
        pick    = $urandom_range(0, 9);
        n_exons = (pick < 7) ? $urandom_range(1, 4) :
                  (pick < 9) ? $urandom_range(5, 12) : $urandom_range(30, 34);
        cur     = $urandom;
        for (int i = 0; i < n_exons; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b = $urandom;
                f = $urandom;
            end
            else
            begin
                b = cur;
                f = cur + $urandom_range(0, 19);
            end
            cur = f + 1 + $urandom_range(0, 30);
            load_exon((i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0),
                      b, f);
        end
        n_reads = $urandom_range(1, 4);
        for (int r = 0; r < n_reads; r++)
        begin
            span = (tx_length < 2000) ? int'(tx_length) : 2000;
            if ($urandom_range(0, 4) == 0)
                query_read(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                           LEN_W'($urandom_range(1, 65535)));
            else
            begin
                off     = $urandom_range(0, span + 3);
                len_max = ((span > off) ? int'(span - off) : 0) + 3;
                query_read(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), off,
                           LEN_W'($urandom_range(1, len_max)));
            end
        end
    endtask

    // Random transcripts under several sender idle rates.
    task automatic test_random_traffic();
        int idle_steps [4] = '{0, 59, 0, 25};
        int goal;
        foreach (idle_steps[p])
        begin
            idle_pct = idle_steps[p];
            goal     = items_sent + 30;
            while (items_sent < goal)
                rand_transcript();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_plus_strand();
        test_minus_strand();
        test_unordered_exons();
        test_coord_extremes();
        test_random_traffic();
        start <= 1'b0;
        while (exp_head != exp_tail)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("transcript_to_genome_cigar regression: pass");
        else
            $display("transcript_to_genome_cigar regression: fail");
        $finish;
    end

endmodule

// ===== transcript_to_genome_cigar.f =====
+incdir+design
design/t2g_pkg.sv
design/t2g_ram.sv
design/t2g_front.sv
design/t2g_fifo.sv
design/t2g_back.sv
design/transcript_to_genome_cigar.sv
design/t2g_checker.sv
dv/transcript_to_genome_cigar_tb.sv
